@@ sv/fta_pkg.sv @@
`default_nettype none

package fta_pkg;

    // Field widths
    localparam int TS_W     = 48;
    localparam int SAMPLE_W = 32;
    localparam int RATE_W   = 16;
    localparam int ACC_W    = SAMPLE_W + 1;

    // Averaging window
    localparam int WIN_DEPTH  = 64;
    localparam int PTR_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W      = SAMPLE_W + CNT_W - 1;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    // Reset value of ticks_per_second
    localparam logic [SAMPLE_W-1:0] TPS_RESET = SAMPLE_W'(10000000);

    // Event codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // take the input transaction
        logic exec;       // apply event / measure frame time
        logic test;       // outlier test, issue ring read
        logic update;     // ring write, count, rate accounting
        logic add;        // add new sample to window sum
        logic div_init;   // load divider
        logic div_step;   // one quotient bit
        logic avg_load;   // latch window mean
        logic tot;        // first half of total time
        logic load_out;   // load output register
    } fta_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic run_tick;   // captured event is a frame tick while running
        logic cnt_zero;   // window is empty
    } fta_status_t;

endpackage

`default_nettype wire

@@ sv/fta_datapath.sv @@
`default_nettype none

module fta_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [fta_pkg::SAMPLE_W-1:0]    cfg_wdata,
    input  wire logic [fta_pkg::TS_W-1:0]        s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire fta_pkg::fta_cmd_t               cmd,
    output fta_pkg::fta_status_t                 status,
    output logic [95:0]                          m_tdata,
    output logic [0:0]                           m_tuser
);

    localparam int TS_W  = fta_pkg::TS_W;
    localparam int SW    = fta_pkg::SAMPLE_W;
    localparam int RW    = fta_pkg::RATE_W;
    localparam int AW    = fta_pkg::ACC_W;
    localparam int PTR_W = fta_pkg::PTR_W;
    localparam int CNT_W = fta_pkg::CNT_W;
    localparam int SUM_W = fta_pkg::SUM_W;

    // Captured transaction and config
    fta_pkg::req_t     req_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [SW-1:0]     tps_reg;

    // Timer state
    logic [TS_W-1:0]   last_reg, last_next;
    logic [TS_W-1:0]   cur_reg, cur_next;
    logic [TS_W-1:0]   base_reg, base_next;
    logic [TS_W-1:0]   stop_reg, stop_next;
    logic [TS_W-1:0]   paused_reg, paused_next;
    logic              stopped_reg, stopped_next;

    // Window state
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SW-1:0]     avg_reg, avg_next;

    // Rate state
    logic [RW-1:0]     frames_reg, frames_next;
    logic [AW-1:0]     accum_reg, accum_next;
    logic [RW-1:0]     rate_reg, rate_next;

    // Working registers
    logic [SW-1:0]     e_reg, e_next;
    logic              ok_reg, ok_next;
    logic [TS_W-1:0]   tot_reg, tot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;

    // Output register
    logic [SW-1:0]     out_avg_reg;
    logic [RW-1:0]     out_rate_reg;
    logic [TS_W-1:0]   out_total_reg;
    logic              out_stopped_reg;

    // Sample ring
    logic [SW-1:0]     ring_mem [fta_pkg::WIN_DEPTH];
    logic [SW-1:0]     ring_q;

    logic [TS_W-1:0]   delta;
    logic [SW-1:0]     diff;
    logic [AW-1:0]     acc_sum;
    logic [RW-1:0]     frames_inc;
    logic              full;
    logic [CNT_W+1:0]  trial;

    assign full       = (count_reg == CNT_W'(fta_pkg::WIN_DEPTH));
    assign delta      = ts_reg - last_reg;
    assign diff       = (e_reg >= avg_reg) ? (e_reg - avg_reg) : (avg_reg - e_reg);
    assign acc_sum    = accum_reg + {1'b0, e_reg};
    assign frames_inc = (&frames_reg) ? frames_reg : frames_reg + RW'(1);
    assign trial      = {1'b0, rem_reg, quo_reg[SUM_W-1]} - {2'b00, count_reg};

    assign status.run_tick = (req_reg == fta_pkg::REQ_TICK) && !stopped_reg;
    assign status.cnt_zero = (count_reg == '0);

    // Next-state logic for all event, window, rate and working state
    always_comb begin
        last_next    = last_reg;
        cur_next     = cur_reg;
        base_next    = base_reg;
        stop_next    = stop_reg;
        paused_next  = paused_reg;
        stopped_next = stopped_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        frames_next  = frames_reg;
        accum_next   = accum_reg;
        rate_next    = rate_reg;
        e_next       = e_reg;
        ok_next      = ok_reg;
        tot_next     = tot_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;

        if (cmd.exec) begin
            unique case (req_reg)
                fta_pkg::REQ_TICK: begin
                    if (stopped_reg) begin
                        avg_next = '0;
                    end else begin
                        e_next    = (|delta[TS_W-1:SW]) ? '1 : delta[SW-1:0];
                        cur_next  = ts_reg;
                        last_next = ts_reg;
                    end
                end
                fta_pkg::REQ_START: begin
                    if (stopped_reg) begin
                        paused_next  = paused_reg + ts_reg - stop_reg;
                        last_next    = ts_reg;
                        stop_next    = '0;
                        stopped_next = 1'b0;
                    end
                end
                fta_pkg::REQ_STOP: begin
                    if (!stopped_reg) begin
                        stop_next    = ts_reg;
                        stopped_next = 1'b1;
                    end
                end
                fta_pkg::REQ_RESET: begin
                    base_next    = ts_reg;
                    last_next    = ts_reg;
                    stop_next    = '0;
                    paused_next  = '0;
                    stopped_next = 1'b0;
                end
                default: begin
                    stopped_next = stopped_reg;
                end
            endcase
        end

        // Outlier test against the current mean
        if (cmd.test) begin
            ok_next = (diff < tps_reg);
        end

        // Window bookkeeping and frame-rate accounting
        if (cmd.update) begin
            if (ok_reg) begin
                if (full) begin
                    sum_next = sum_reg - {{(SUM_W-SW){1'b0}}, ring_q};
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
                ptr_next = (ptr_reg == PTR_W'(fta_pkg::WIN_DEPTH - 1)) ? '0
                                                                       : ptr_reg + PTR_W'(1);
            end
            if (acc_sum > {1'b0, tps_reg}) begin
                rate_next   = frames_inc;
                frames_next = '0;
                accum_next  = '0;
            end else begin
                frames_next = frames_inc;
                accum_next  = acc_sum;
            end
        end

        if (cmd.add && ok_reg) begin
            sum_next = sum_reg + {{(SUM_W-SW){1'b0}}, e_reg};
        end

        // Restoring divider: window_sum / sample_count
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = sum_reg;
        end
        if (cmd.div_step) begin
            if (trial[CNT_W+1]) begin
                rem_next = {rem_reg[CNT_W-2:0], quo_reg[SUM_W-1]};
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
        end
        if (cmd.avg_load) begin
            avg_next = status.cnt_zero ? '0 : quo_reg[SW-1:0];
        end

        // End stamp less paused time; base is taken off at output load
        if (cmd.tot) begin
            tot_next = (stopped_reg ? stop_reg : cur_reg) - paused_reg;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg     <= fta_pkg::TPS_RESET;
            last_reg    <= '0;
            cur_reg     <= '0;
            base_reg    <= '0;
            stop_reg    <= '0;
            paused_reg  <= '0;
            stopped_reg <= 1'b0;
            ptr_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            frames_reg  <= '0;
            accum_reg   <= '0;
            rate_reg    <= '0;
        end else begin
            if (cfg_we) begin
                tps_reg <= cfg_wdata;
            end
            last_reg    <= last_next;
            cur_reg     <= cur_next;
            base_reg    <= base_next;
            stop_reg    <= stop_next;
            paused_reg  <= paused_next;
            stopped_reg <= stopped_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            frames_reg  <= frames_next;
            accum_reg   <= accum_next;
            rate_reg    <= rate_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= fta_pkg::req_t'(s_tuser);
            ts_reg  <= s_tdata;
        end
        e_reg   <= e_next;
        ok_reg  <= ok_next;
        tot_reg <= tot_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_out) begin
            out_avg_reg     <= avg_reg;
            out_rate_reg    <= rate_reg;
            out_total_reg   <= tot_reg - base_reg;
            out_stopped_reg <= stopped_reg;
        end
    end

    // Sample ring: one write port, registered read at the write pointer
    always_ff @(posedge aclk) begin
        if (cmd.update && ok_reg) begin
            ring_mem[ptr_reg] <= e_reg;
        end
        ring_q <= ring_mem[ptr_reg];
    end

    assign m_tdata = {out_total_reg, out_rate_reg, out_avg_reg};
    assign m_tuser = out_stopped_reg;

endmodule

`default_nettype wire

@@ sv/fta_ctrl.sv @@
`default_nettype none

module fta_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire fta_pkg::fta_status_t  status,
    output fta_pkg::fta_cmd_t          cmd
);

    localparam int DCW = fta_pkg::DIV_CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TEST,
        S_UPDATE,
        S_ADD,
        S_DIV_INIT,
        S_DIV,
        S_AVG,
        S_TOT,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Sequencing and commands
    always_comb begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;

        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.run_tick ? S_TEST : S_TOT;
            end
            S_TEST: begin
                cmd.test   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = status.cnt_zero ? S_AVG : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(fta_pkg::SUM_W - 1)) begin
                    state_next = S_AVG;
                end
            end
            S_AVG: begin
                cmd.avg_load = 1'b1;
                state_next   = S_TOT;
            end
            S_TOT: begin
                cmd.tot    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to drain
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/frame_time_averager.sv @@
// Channel   Dir  tdata (lsb first)                              tuser
// s_        in   timestamp[47:0]                                req_type[1:0]
// m_        out  avg_frame_ticks[31:0] frame_rate[47:32]        is_stopped[0]
//                total_ticks[95:48]
// cfg_      in   ticks_per_second[31:0], written when cfg_we is high
//
// Start, stop and reset events and a tick while stopped run the execute, total and
// output steps; a running frame tick adds the outlier test, window update and sum and
// the 38-step shift-subtract divider for the mean, skipped while the window is empty.
// One event is in flight; the next is accepted once the result sits in the output
// register, even if the sink has not taken it; a stalled sink holds the last step.
// aresetn is synchronous; the sample ring needs no clearing after reset.
`default_nettype none

module frame_time_averager (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [fta_pkg::SAMPLE_W-1:0]  cfg_wdata,   // ticks_per_second
    // events in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fta_pkg::TS_W-1:0]      s_tdata,     // timestamp
    input  wire logic [1:0]                    s_tuser,     // req_type
    // results out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [95:0]                        m_tdata,     // avg_frame_ticks, frame_rate,
                                                            // total_ticks
    output logic [0:0]                         m_tuser      // is_stopped
);

    fta_pkg::fta_cmd_t     cmd;
    fta_pkg::fta_status_t  status;

    fta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fta_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/fta_checker.sv @@
`default_nettype none

module fta_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [95:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A waiting result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // One event in flight: input closes right after a transaction
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second event taken while one is in flight");

    // No result is offered out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind frame_time_averager fta_checker u_fta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
